/* sv/gmt_pkg.sv */
`default_nettype none
package gmt_pkg;

   localparam logic [1:0] CMD_MERGE = 2'd0;
   localparam logic [1:0] CMD_TICK  = 2'd1;
   localparam logic [1:0] CMD_ACK   = 2'd2;
   localparam logic [1:0] CMD_BEAT  = 2'd3;

   localparam logic [1:0] ST_ALIVE   = 2'd0;
   localparam logic [1:0] ST_SUSPECT = 2'd1;
   localparam logic [1:0] ST_FAIL    = 2'd2;
   localparam logic [1:0] ST_LEAVE   = 2'd3;

   localparam logic [2:0] REG_SUSPECT_ENABLED = 3'd0;
   localparam logic [2:0] REG_SELF_SLOT       = 3'd1;
   localparam logic [2:0] REG_SUSPECT_TICKS   = 3'd2;
   localparam logic [2:0] REG_FAIL_TICKS      = 3'd3;
   localparam logic [2:0] REG_CLEANUP_TICKS   = 3'd4;

   typedef struct packed {
      logic [1:0]  command;
      logic [4:0]  slot;
      logic [31:0] in_heartbeat;
      logic [15:0] in_incarnation;
      logic [1:0]  in_status;
   } req_word_type;

   typedef struct packed {
      logic [4:0]  out_slot;
      logic        out_valid;
      logic [1:0]  out_status;
      logic [31:0] out_heartbeat;
      logic [15:0] out_incarnation;
      logic [5:0]  suspected_count;
      logic [5:0]  failed_count;
      logic [5:0]  removed_count;
   } rsp_word_type;

   typedef struct packed {
      logic        suspect_enabled;
      logic [4:0]  self_slot;
      logic [15:0] suspect_ticks;
      logic [15:0] fail_ticks;
      logic [15:0] cleanup_ticks;
   } cfg_type;

   // Controller to datapath.
   typedef struct packed {
      logic latch_req;    // capture the request word
      logic read_self;    // read the own entry (tick check)
      logic read_slot;    // read the entry at the sweep/target address
      logic apply;        // write back the modified entry
      logic sweep_clear;  // reset the sweep counter and counts
      logic sweep_next;   // advance the sweep counter
      logic load_rsp;     // capture the final response read
      logic read_rsp;     // read the response slot
   } gmt_cmd_type;

   typedef struct packed {
      logic sweep_last;
      logic is_tick;
   } gmt_stat_type;

endpackage
`default_nettype wire

/* sv/gossip_membership_table_top.sv */
`default_nettype none
// Gossip membership table with a SWIM-style failure detector.
// Commands enter on the req_ port: a word is accepted at a rising edge where
// start is high and busy is low. Merge, ack and beat read one table entry,
// modify it and write it back; tick sweeps every slot, aging entries and
// applying suspicion, failure and cleanup timeouts while the own entry is
// Alive. Each command gives exactly one response word on rsp_word, shown for
// one cycle while rsp_strobe is high; the receiver cannot hold it off.
// A merge, ack or beat runs from acceptance through the own-entry read, the
// entry read, the write-back and the response read and load; busy drops in
// the cycle after the strobe. A tick reads and writes back each slot in turn,
// as the entry memory has a single read and write port.
// Reset (synchronous, active high) clears all valid bits, so the table is
// empty, and loads the registers with their defaults: suspicion on, own slot
// 0 and timeouts of 20, 40 and 60 ticks.
// Registers are written through the csr_ APB-style port at byte addresses
// 4*i; the user must write them only while the block is idle (not enforced).
module gossip_membership_table_top #(
   parameter int TABLE_SLOTS = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire gmt_pkg::req_word_type req_word,
   output logic                       rsp_strobe,
   output gmt_pkg::rsp_word_type      rsp_word,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [4:0]            csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);

   gmt_pkg::cfg_type      cfg_ff;
   gmt_pkg::gmt_cmd_type  cmd;
   gmt_pkg::gmt_stat_type stat;
   logic [2:0]            reg_idx;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[4:2];

   // Register file; low address bits are ignored as the word is 32 bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.suspect_enabled <= 1'b1;
         cfg_ff.self_slot       <= 5'd0;
         cfg_ff.suspect_ticks   <= 16'd20;
         cfg_ff.fail_ticks      <= 16'd40;
         cfg_ff.cleanup_ticks   <= 16'd60;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (reg_idx)
            gmt_pkg::REG_SUSPECT_ENABLED: cfg_ff.suspect_enabled <= csr_pwdata[0];
            gmt_pkg::REG_SELF_SLOT:       cfg_ff.self_slot       <= csr_pwdata[4:0];
            gmt_pkg::REG_SUSPECT_TICKS:   cfg_ff.suspect_ticks   <= csr_pwdata[15:0];
            gmt_pkg::REG_FAIL_TICKS:      cfg_ff.fail_ticks      <= csr_pwdata[15:0];
            gmt_pkg::REG_CLEANUP_TICKS:   cfg_ff.cleanup_ticks   <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         gmt_pkg::REG_SUSPECT_ENABLED: csr_prdata = {31'd0, cfg_ff.suspect_enabled};
         gmt_pkg::REG_SELF_SLOT:       csr_prdata = {27'd0, cfg_ff.self_slot};
         gmt_pkg::REG_SUSPECT_TICKS:   csr_prdata = {16'd0, cfg_ff.suspect_ticks};
         gmt_pkg::REG_FAIL_TICKS:      csr_prdata = {16'd0, cfg_ff.fail_ticks};
         gmt_pkg::REG_CLEANUP_TICKS:   csr_prdata = {16'd0, cfg_ff.cleanup_ticks};
         default:                      csr_prdata = 32'd0;
      endcase
   end

   gmt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .stat       (stat),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd)
   );

   gmt_datapath #(.TABLE_SLOTS(TABLE_SLOTS)) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .req_word (req_word),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_word (rsp_word)
   );

endmodule
`default_nettype wire

/* sv/gmt_datapath.sv */
`default_nettype none
module gmt_datapath #(
   parameter int TABLE_SLOTS = 32
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire gmt_pkg::cfg_type     cfg,
   input  wire gmt_pkg::req_word_type req_word,
   input  wire gmt_pkg::gmt_cmd_type cmd,
   output gmt_pkg::gmt_stat_type     stat,
   output gmt_pkg::rsp_word_type     rsp_word
);

   localparam int IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

   // Table entries live in one memory word each; valid bits in flip-flops.
   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] heartbeat;
      logic [15:0] incarnation;
      logic [15:0] age;
   } entry_type;

   entry_type                 mem [TABLE_SLOTS];
   logic [TABLE_SLOTS-1:0]    valid_ff;
   gmt_pkg::req_word_type     req_ff;
   entry_type                 rd_ff;
   logic                      rd_valid_ff;
   logic                      self_active_ff;
   logic                      self_read_ff;
   logic [IW:0]               sweep_ff;
   logic [5:0]                sus_ff, fail_ff, rem_ff;
   logic [5:0]                sus_in, fail_in, rem_in;
   gmt_pkg::rsp_word_type     rsp_ff;

   // Address of the last read, used for write-back.
   logic [IW-1:0] rd_addr_ff;
   logic          rd_addr_ok_ff;

   logic [IW:0]  addr_full;
   logic [IW-1:0] addr;
   logic          addr_ok;
   logic [4:0]    rsp_slot;
   logic          self_ok;
   logic          rsp_ok;
   logic          is_tick;

   assign is_tick  = (req_ff.command == gmt_pkg::CMD_TICK);
   assign rsp_slot = (req_ff.command == gmt_pkg::CMD_MERGE ||
                      req_ff.command == gmt_pkg::CMD_ACK) ? req_ff.slot : cfg.self_slot;
   assign self_ok  = (7'(cfg.self_slot) < 7'(TABLE_SLOTS));
   assign rsp_ok   = (7'(rsp_slot) < 7'(TABLE_SLOTS));

   // Address of the entry this cycle works on.
   always_comb begin
      if (cmd.read_self) begin
         addr_full = (IW+1)'(cfg.self_slot);
         addr_ok   = self_ok;
      end else if (is_tick && !cmd.read_rsp) begin
         addr_full = sweep_ff;
         addr_ok   = (sweep_ff < (IW+1)'(TABLE_SLOTS));
      end else begin
         addr_full = (IW+1)'(rsp_slot);
         addr_ok   = rsp_ok;
      end
      addr = addr_full[IW-1:0];
   end

   // Read-modify-write target computed from the registered read.
   entry_type    nx;
   logic         nx_valid;
   logic         do_write;
   logic [15:0]  age;
   always_comb begin
      nx       = rd_ff;
      nx_valid = rd_valid_ff;
      do_write = 1'b0;
      sus_in   = sus_ff;
      fail_in  = fail_ff;
      rem_in   = rem_ff;
      age      = '0;
      unique case (req_ff.command)
         gmt_pkg::CMD_MERGE: begin
            do_write = 1'b1;
            if (!rd_valid_ff || req_ff.in_incarnation > rd_ff.incarnation ||
                (req_ff.in_incarnation == rd_ff.incarnation &&
                 (req_ff.in_status == gmt_pkg::ST_FAIL ||
                  req_ff.in_status == gmt_pkg::ST_LEAVE))) begin
               nx_valid       = 1'b1;
               nx.status      = req_ff.in_status;
               nx.heartbeat   = req_ff.in_heartbeat;
               nx.incarnation = req_ff.in_incarnation;
               nx.age         = '0;
            end else if (req_ff.in_incarnation == rd_ff.incarnation) begin
               if (cfg.suspect_enabled) begin
                  if (req_ff.slot == cfg.self_slot) begin
                     if (req_ff.in_status == gmt_pkg::ST_SUSPECT) begin
                        if (nx.incarnation != 16'hFFFF)
                           nx.incarnation = nx.incarnation + 16'd1;
                        nx.status = gmt_pkg::ST_ALIVE;
                        nx.age    = '0;
                     end
                  end else if (req_ff.in_status == gmt_pkg::ST_SUSPECT &&
                               nx.status == gmt_pkg::ST_ALIVE) begin
                     nx.status = gmt_pkg::ST_SUSPECT;
                     nx.age    = '0;
                  end else if (req_ff.in_status == gmt_pkg::ST_ALIVE &&
                               nx.status == gmt_pkg::ST_SUSPECT) begin
                     nx.status = gmt_pkg::ST_ALIVE;
                     nx.age    = '0;
                  end
               end
               if (req_ff.in_status == gmt_pkg::ST_ALIVE && nx.status == gmt_pkg::ST_ALIVE &&
                   req_ff.in_heartbeat >= nx.heartbeat) begin
                  nx.heartbeat = req_ff.in_heartbeat;
                  nx.age       = '0;
               end
            end
         end
         gmt_pkg::CMD_ACK: begin
            do_write = rd_valid_ff;
            nx.age   = '0;
         end
         gmt_pkg::CMD_BEAT: begin
            do_write     = rd_valid_ff && rd_ff.status == gmt_pkg::ST_ALIVE;
            nx.heartbeat = rd_ff.heartbeat + 32'd1;
         end
         gmt_pkg::CMD_TICK: begin
            do_write = rd_valid_ff;
            age      = (rd_ff.age != 16'hFFFF) ? rd_ff.age + 16'd1 : rd_ff.age;
            nx.age   = age;
            if (self_active_ff && rd_valid_ff &&
                (7'(cfg.self_slot) != 7'(sweep_ff))) begin
               if (cfg.suspect_enabled) begin
                  if (rd_ff.status == gmt_pkg::ST_ALIVE && age > cfg.suspect_ticks) begin
                     nx.status = gmt_pkg::ST_SUSPECT;
                     nx.age    = '0;
                     sus_in    = sus_ff + 6'd1;
                  end else if (rd_ff.status == gmt_pkg::ST_SUSPECT && age > cfg.fail_ticks) begin
                     nx.status = gmt_pkg::ST_FAIL;
                     nx.age    = '0;
                     fail_in   = fail_ff + 6'd1;
                  end
               end else if ((rd_ff.status == gmt_pkg::ST_ALIVE && age > cfg.fail_ticks) ||
                            rd_ff.status == gmt_pkg::ST_SUSPECT) begin
                  nx.status = gmt_pkg::ST_FAIL;
                  nx.age    = '0;
                  fail_in   = fail_ff + 6'd1;
               end
               if ((nx.status == gmt_pkg::ST_FAIL || nx.status == gmt_pkg::ST_LEAVE) &&
                   age > cfg.cleanup_ticks) begin
                  nx       = '0;
                  nx_valid = 1'b0;
                  rem_in   = rem_ff + 6'd1;
               end
            end
         end
         default: ;
      endcase
   end

   assign stat.sweep_last = (sweep_ff == (IW+1)'(TABLE_SLOTS - 1));
   assign stat.is_tick    = is_tick;

   always_ff @(posedge clock) begin
      if (cmd.latch_req)
         req_ff <= req_word;
      if (cmd.read_self || cmd.read_slot || cmd.read_rsp) begin
         rd_ff       <= mem[addr];
         rd_valid_ff <= addr_ok && valid_ff[addr];
      end
      if (cmd.apply && do_write && rd_addr_ok_ff)
         mem[rd_addr_ff] <= nx;
      if (cmd.load_rsp)
         rsp_ff <= '{out_slot: rsp_slot,
                     out_valid: rd_valid_ff,
                     out_status: rd_valid_ff ? rd_ff.status : 2'd0,
                     out_heartbeat: rd_valid_ff ? rd_ff.heartbeat : 32'd0,
                     out_incarnation: rd_valid_ff ? rd_ff.incarnation : 16'd0,
                     suspected_count: is_tick ? sus_ff : 6'd0,
                     failed_count: is_tick ? fail_ff : 6'd0,
                     removed_count: is_tick ? rem_ff : 6'd0};
   end

   always_ff @(posedge clock) begin
      if (cmd.read_self || cmd.read_slot || cmd.read_rsp) begin
         rd_addr_ff    <= addr;
         rd_addr_ok_ff <= addr_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff       <= '0;
         sweep_ff       <= '0;
         sus_ff         <= '0;
         fail_ff        <= '0;
         rem_ff         <= '0;
         self_active_ff <= 1'b0;
         self_read_ff   <= 1'b0;
      end else begin
         if (cmd.apply && do_write && rd_addr_ok_ff)
            valid_ff[rd_addr_ff] <= nx_valid;
         // The own entry read lands in rd_ff in the cycle after the read.
         self_read_ff <= cmd.read_self;
         if (self_read_ff)
            self_active_ff <= rd_valid_ff && rd_ff.status == gmt_pkg::ST_ALIVE;
         if (cmd.sweep_clear) begin
            sweep_ff <= '0;
            sus_ff   <= '0;
            fail_ff  <= '0;
            rem_ff   <= '0;
         end else begin
            if (cmd.apply && is_tick) begin
               sus_ff  <= sus_in;
               fail_ff <= fail_in;
               rem_ff  <= rem_in;
            end
            if (cmd.sweep_next)
               sweep_ff <= sweep_ff + (IW+1)'(1);
         end
      end
   end

   assign rsp_word = rsp_ff;

endmodule
`default_nettype wire

/* sv/gmt_ctrl.sv */
`default_nettype none
module gmt_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire gmt_pkg::gmt_stat_type stat,
   output logic                      busy,
   output logic                      rsp_strobe,
   output gmt_pkg::gmt_cmd_type      cmd
);

   typedef enum logic [2:0] {
      S_IDLE, S_SELF, S_READ, S_APPLY, S_RSP_READ, S_RSP_LOAD, S_DONE
   } state_type;

   state_type state_ff;
   logic      strobe_ff;

   always_comb begin
      cmd            = '0;
      cmd.latch_req  = (state_ff == S_IDLE) && start;
      cmd.sweep_clear = (state_ff == S_IDLE) && start;
      cmd.read_self  = (state_ff == S_SELF);
      cmd.read_slot  = (state_ff == S_READ);
      cmd.apply      = (state_ff == S_APPLY);
      cmd.sweep_next = (state_ff == S_APPLY) && stat.is_tick;
      cmd.read_rsp   = (state_ff == S_RSP_READ);
      cmd.load_rsp   = (state_ff == S_RSP_LOAD);
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = strobe_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE:     if (start) state_ff <= S_SELF;
            S_SELF:     state_ff <= S_READ;
            S_READ:     state_ff <= S_APPLY;
            S_APPLY:    state_ff <= (stat.is_tick && !stat.sweep_last) ? S_READ : S_RSP_READ;
            S_RSP_READ: state_ff <= S_RSP_LOAD;
            S_RSP_LOAD: begin
               state_ff  <= S_DONE;
               strobe_ff <= 1'b1;
            end
            S_DONE:     state_ff <= S_IDLE;
            default:    state_ff <= S_IDLE;
         endcase
      end
   end

endmodule
`default_nettype wire

/* bench/gossip_membership_table_top_test.sv */
`timescale 1ns / 1ps
`default_nettype none
module gossip_membership_table_top_test;

   localparam int SLOTS = 32;
   localparam int CYCLE_LIMIT = 900000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   gmt_pkg::req_word_type req_word = '0;
   logic rsp_strobe;
   gmt_pkg::rsp_word_type rsp_word;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [4:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   gossip_membership_table_top #(.TABLE_SLOTS(SLOTS)) i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_word(req_word), .rsp_strobe(rsp_strobe), .rsp_word(rsp_word),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #2 clock = ~clock;

   // Our own copy of the membership table and the register settings.
   logic        tbl_valid [SLOTS];
   logic [1:0]  tbl_status [SLOTS];
   logic [31:0] tbl_heartbeat [SLOTS];
   logic [15:0] tbl_incarnation [SLOTS];
   logic [15:0] tbl_age [SLOTS];
   gmt_pkg::cfg_type cfg;

   gmt_pkg::rsp_word_type pending_words [$];
   int error_count = 0;
   int cycle_count = 0;
   bit quiet_sender = 0;

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      error_count++;
      $display("mismatch %s: got %0h, expected %0h (t=%0t)", what, got, want, $realtime);
   endtask

   function automatic bit own_alive();
      return cfg.self_slot < SLOTS && tbl_valid[cfg.self_slot] &&
             tbl_status[cfg.self_slot] == gmt_pkg::ST_ALIVE;
   endfunction

   function automatic void table_clear(input int s);
      tbl_valid[s] = 0;
      tbl_status[s] = gmt_pkg::ST_ALIVE;
      tbl_heartbeat[s] = '0;
      tbl_incarnation[s] = '0;
      tbl_age[s] = '0;
   endfunction

   function automatic void table_load(input int s, input gmt_pkg::req_word_type w);
      tbl_valid[s] = 1;
      tbl_status[s] = w.in_status;
      tbl_heartbeat[s] = w.in_heartbeat;
      tbl_incarnation[s] = w.in_incarnation;
      tbl_age[s] = '0;
   endfunction

   // Incarnation-first merge of one gossiped entry.
   function automatic void merge_entry(input gmt_pkg::req_word_type w);
      int s;
      s = w.slot;
      if (!tbl_valid[s] || w.in_incarnation > tbl_incarnation[s]) begin
         table_load(s, w);
         return;
      end
      if (w.in_incarnation < tbl_incarnation[s]) return;
      if (w.in_status == gmt_pkg::ST_FAIL || w.in_status == gmt_pkg::ST_LEAVE) begin
         table_load(s, w);
         return;
      end
      if (cfg.suspect_enabled) begin
         if (s == cfg.self_slot) begin
            // Refute suspicion of ourselves with a newer incarnation.
            if (w.in_status == gmt_pkg::ST_SUSPECT) begin
               if (tbl_incarnation[s] != 16'hFFFF) tbl_incarnation[s]++;
               tbl_status[s] = gmt_pkg::ST_ALIVE;
               tbl_age[s] = '0;
            end
         end else if (w.in_status == gmt_pkg::ST_SUSPECT &&
                      tbl_status[s] == gmt_pkg::ST_ALIVE) begin
            tbl_status[s] = gmt_pkg::ST_SUSPECT;
            tbl_age[s] = '0;
         end else if (w.in_status == gmt_pkg::ST_ALIVE &&
                      tbl_status[s] == gmt_pkg::ST_SUSPECT) begin
            tbl_status[s] = gmt_pkg::ST_ALIVE;
            tbl_age[s] = '0;
         end
      end
      if (w.in_status == gmt_pkg::ST_ALIVE && tbl_status[s] == gmt_pkg::ST_ALIVE &&
          w.in_heartbeat >= tbl_heartbeat[s]) begin
         tbl_heartbeat[s] = w.in_heartbeat;
         tbl_age[s] = '0;
      end
   endfunction

   function automatic gmt_pkg::rsp_word_type predict_membership(input gmt_pkg::req_word_type w);
      gmt_pkg::rsp_word_type r;
      int rs;
      bit active;
      logic [15:0] age;
      r = '0;
      case (w.command)
         gmt_pkg::CMD_MERGE: begin
            rs = w.slot;
            merge_entry(w);
         end
         gmt_pkg::CMD_TICK: begin
            rs = cfg.self_slot;
            active = own_alive();
            for (int s = 0; s < SLOTS; s++)
               if (tbl_valid[s] && tbl_age[s] != 16'hFFFF) tbl_age[s]++;
            if (active) begin
               for (int s = 0; s < SLOTS; s++) begin
                  if (!tbl_valid[s] || s == cfg.self_slot) continue;
                  age = tbl_age[s];
                  if (cfg.suspect_enabled) begin
                     if (tbl_status[s] == gmt_pkg::ST_ALIVE && age > cfg.suspect_ticks) begin
                        tbl_status[s] = gmt_pkg::ST_SUSPECT;
                        tbl_age[s] = '0;
                        r.suspected_count++;
                     end else if (tbl_status[s] == gmt_pkg::ST_SUSPECT &&
                                  age > cfg.fail_ticks) begin
                        tbl_status[s] = gmt_pkg::ST_FAIL;
                        tbl_age[s] = '0;
                        r.failed_count++;
                     end
                  end else if ((tbl_status[s] == gmt_pkg::ST_ALIVE && age > cfg.fail_ticks) ||
                               tbl_status[s] == gmt_pkg::ST_SUSPECT) begin
                     tbl_status[s] = gmt_pkg::ST_FAIL;
                     tbl_age[s] = '0;
                     r.failed_count++;
                  end
                  // Cleanup looks at the age from before any transition.
                  if ((tbl_status[s] == gmt_pkg::ST_FAIL || tbl_status[s] == gmt_pkg::ST_LEAVE) &&
                      age > cfg.cleanup_ticks) begin
                     table_clear(s);
                     r.removed_count++;
                  end
               end
            end
         end
         gmt_pkg::CMD_ACK: begin
            rs = w.slot;
            if (tbl_valid[rs]) tbl_age[rs] = '0;
         end
         default: begin
            rs = cfg.self_slot;
            if (own_alive()) tbl_heartbeat[rs] = tbl_heartbeat[rs] + 32'd1;
         end
      endcase
      r.out_slot = 5'(rs);
      r.out_valid = tbl_valid[rs];
      r.out_status = tbl_status[rs];
      r.out_heartbeat = tbl_heartbeat[rs];
      r.out_incarnation = tbl_incarnation[rs];
      return r;
   endfunction

   // Sends one command word; waits for the block to accept it.
   task automatic send_word(input gmt_pkg::req_word_type w);
      @(negedge clock);
      if (!quiet_sender)
         while ($urandom_range(99) < 9) @(negedge clock);
      req_word <= w;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_words.insert(pending_words.size(), predict_membership(w));
      @(negedge clock);
      start <= 1'b0;
   endtask

   task automatic send_cmd(input logic [1:0] c, input int s, input logic [31:0] hb,
                           input logic [15:0] inc, input logic [1:0] st);
      gmt_pkg::req_word_type w;
      w.command = c;
      w.slot = 5'(s);
      w.in_heartbeat = hb;
      w.in_incarnation = inc;
      w.in_status = st;
      send_word(w);
   endtask

   // Waits for all responses, then for the longest command to finish.
   task automatic drain();
      while (pending_words.size() != 0) @(negedge clock);
      repeat (2 * SLOTS + 10) @(negedge clock);
   endtask

   task automatic write_register(input logic [2:0] index, input logic [31:0] value);
      logic [31:0] want;
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      case (index)
         gmt_pkg::REG_SUSPECT_ENABLED: begin
            cfg.suspect_enabled = value[0];
            want = 32'(value[0]);
         end
         gmt_pkg::REG_SELF_SLOT: begin
            cfg.self_slot = value[4:0];
            want = 32'(value[4:0]);
         end
         gmt_pkg::REG_SUSPECT_TICKS: begin
            cfg.suspect_ticks = value[15:0];
            want = 32'(value[15:0]);
         end
         gmt_pkg::REG_FAIL_TICKS: begin
            cfg.fail_ticks = value[15:0];
            want = 32'(value[15:0]);
         end
         default: begin
            cfg.cleanup_ticks = value[15:0];
            want = 32'(value[15:0]);
         end
      endcase
      // The register reads back its new value while the address is still up.
      if (csr_prdata !== want)
         report("register read", csr_prdata, want);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic set_timeouts(input logic en, input int self, input int sus,
                               input int fl, input int cl);
      drain();
      write_register(gmt_pkg::REG_SUSPECT_ENABLED, 32'(en));
      write_register(gmt_pkg::REG_SELF_SLOT, self);
      write_register(gmt_pkg::REG_SUSPECT_TICKS, sus);
      write_register(gmt_pkg::REG_FAIL_TICKS, fl);
      write_register(gmt_pkg::REG_CLEANUP_TICKS, cl);
   endtask

   // Every response is checked against the oldest prediction.
   always @(posedge clock) begin
      gmt_pkg::rsp_word_type want;
      if (!reset && rsp_strobe) begin
         if (pending_words.size() == 0) begin
            report("unexpected response", 32'(rsp_word.out_slot), 32'd0);
         end else begin
            want = pending_words.pop_front();
            if (rsp_word.out_slot !== want.out_slot)
               report("out_slot", 32'(rsp_word.out_slot), 32'(want.out_slot));
            if (rsp_word.out_valid !== want.out_valid)
               report("out_valid", 32'(rsp_word.out_valid), 32'(want.out_valid));
            if (rsp_word.out_status !== want.out_status)
               report("out_status", 32'(rsp_word.out_status), 32'(want.out_status));
            if (rsp_word.out_heartbeat !== want.out_heartbeat)
               report("out_heartbeat", rsp_word.out_heartbeat, want.out_heartbeat);
            if (rsp_word.out_incarnation !== want.out_incarnation)
               report("out_incarnation", 32'(rsp_word.out_incarnation),
                      32'(want.out_incarnation));
            if (rsp_word.suspected_count !== want.suspected_count)
               report("suspected_count", 32'(rsp_word.suspected_count),
                      32'(want.suspected_count));
            if (rsp_word.failed_count !== want.failed_count)
               report("failed_count", 32'(rsp_word.failed_count), 32'(want.failed_count));
            if (rsp_word.removed_count !== want.removed_count)
               report("removed_count", 32'(rsp_word.removed_count), 32'(want.removed_count));
         end
      end
   end

   // Watchdog for a hung handshake.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Directed walk through merge rules, refutation, saturation and wrap.
   task automatic test_directed();
      send_cmd(gmt_pkg::CMD_BEAT, 0, 0, 0, gmt_pkg::ST_ALIVE);      // beat with no own entry
      send_cmd(gmt_pkg::CMD_ACK, 5, 0, 0, gmt_pkg::ST_ALIVE);       // ack on an empty slot
      send_cmd(gmt_pkg::CMD_MERGE, 0, 32'hFFFF_FFFF, 16'hFFFF, gmt_pkg::ST_ALIVE);
      send_cmd(gmt_pkg::CMD_BEAT, 0, 0, 0, gmt_pkg::ST_ALIVE);      // heartbeat wraps
      send_cmd(gmt_pkg::CMD_MERGE, 0, 0, 16'hFFFF, gmt_pkg::ST_SUSPECT); // refutation saturates
      send_cmd(gmt_pkg::CMD_MERGE, 31, 10, 3, gmt_pkg::ST_ALIVE);
      send_cmd(gmt_pkg::CMD_MERGE, 31, 9, 3, gmt_pkg::ST_ALIVE);    // older heartbeat kept
      send_cmd(gmt_pkg::CMD_MERGE, 31, 20, 3, gmt_pkg::ST_ALIVE);
      send_cmd(gmt_pkg::CMD_MERGE, 31, 20, 2, gmt_pkg::ST_FAIL);    // lower incarnation
      send_cmd(gmt_pkg::CMD_MERGE, 31, 20, 3, gmt_pkg::ST_SUSPECT);
      send_cmd(gmt_pkg::CMD_MERGE, 31, 20, 3, gmt_pkg::ST_ALIVE);   // back to Alive
      send_cmd(gmt_pkg::CMD_MERGE, 7, 1, 0, gmt_pkg::ST_LEAVE);
      send_cmd(gmt_pkg::CMD_MERGE, 8, 1, 0, gmt_pkg::ST_ALIVE);
      send_cmd(gmt_pkg::CMD_MERGE, 8, 1, 0, gmt_pkg::ST_FAIL);      // equal-incarnation override
      send_cmd(gmt_pkg::CMD_MERGE, 9, 1, 0, gmt_pkg::ST_SUSPECT);
      send_cmd(gmt_pkg::CMD_ACK, 31, 0, 0, gmt_pkg::ST_ALIVE);
      set_timeouts(1, 0, 1, 1, 1);
      repeat (4) send_cmd(gmt_pkg::CMD_TICK, 0, 0, 0, gmt_pkg::ST_ALIVE);
      set_timeouts(0, 0, 16'hFFFF, 1, 2);
      send_cmd(gmt_pkg::CMD_MERGE, 3, 0, 1, gmt_pkg::ST_ALIVE);
      send_cmd(gmt_pkg::CMD_MERGE, 4, 0, 1, gmt_pkg::ST_SUSPECT);
      repeat (4) send_cmd(gmt_pkg::CMD_TICK, 0, 0, 0, gmt_pkg::ST_ALIVE);
   endtask

   // Random traffic: a small cast of slots so entries live long enough to age.
   task automatic test_random(input int count, input bit steady);
      logic [1:0]  c;
      int          s;
      logic [31:0] hb;
      logic [15:0] inc;
      logic [1:0]  st;
      for (int n = 0; n < count; n++) begin
         quiet_sender = steady;
         c = ($urandom_range(99) < 40) ? gmt_pkg::CMD_MERGE : 2'($urandom_range(3));
         s = ($urandom_range(99) < 80) ? int'($urandom_range(7)) : int'($urandom_range(SLOTS - 1));
         if ($urandom_range(99) < 20) s = int'(cfg.self_slot);
         hb = ($urandom_range(99) < 10) ? $urandom() : $urandom_range(40);
         inc = ($urandom_range(99) < 10) ? 16'($urandom_range(16'hFFFF)) : 16'($urandom_range(3));
         st = 2'($urandom_range(3));
         send_cmd(c, s, hb, inc, st);
      end
      quiet_sender = 0;
   endtask

   initial begin
      cfg = '{suspect_enabled: 1'b1, self_slot: 5'd0, suspect_ticks: 16'd20,
              fail_ticks: 16'd40, cleanup_ticks: 16'd60};
      for (int s = 0; s < SLOTS; s++) table_clear(s);
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      set_timeouts(1, 0, 3, 5, 4);
      test_random(400, 0);
      // Sender holds off until the table is fully quiet.
      drain();
      set_timeouts(0, 31, 2, 3, 2);
      test_random(300, 1);
      set_timeouts(1, 2, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      test_random(300, 0);
      set_timeouts(1, 5, 1, 1, 1);
      test_random(300, 0);
      set_timeouts(0, 0, 4, 2, 6);
      test_random(300, 0);
      drain();
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
`default_nettype wire

/* sim.f */
sv/gmt_pkg.sv
sv/gmt_datapath.sv
sv/gmt_ctrl.sv
sv/gossip_membership_table_top.sv
bench/gossip_membership_table_top_test.sv
